FILE: rtl/qrs_pkg.sv
package qrs_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  // Discriminant magnitude: b^2 + 4|ac| needs two bits above the product width.
  localparam int DISC_W    = 2 * DATA_W + 2;
  localparam int ROOT_W    = DISC_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int SQ_STEPS  = DISC_W / 2;
  localparam int NUM_W     = ROOT_W + 3;
  localparam int NMAG_W    = NUM_W - 1;
  localparam int QUO_W     = NMAG_W + FRAC_W;
  localparam int DEN_W     = DATA_W + 1;
  localparam int DIV_STEPS = QUO_W;
  localparam int MIDQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NEG_DISC = 2'd1,
    ST_ZERO_A   = 2'd2,
    ST_SAT      = 2'd3
  } status_e;

  typedef struct packed {
    status_e             st;
    logic                an;
    logic                bn;
    logic [DATA_W-1:0]   ma;
    logic [DATA_W-1:0]   mb;
    logic [DISC_W-1:0]   disc;
  } mid_t;

endpackage

FILE: rtl/quadratic_root_solver.sv
// Throughput: one coefficient triple per cycle while nothing stalls, set by the 33-stage
// square root and the two 51-stage dividers, each of which takes a new request in every
// cycle in which the pipeline is not stalled.
// Reset is asynchronous and active low; it empties both queues and every pipeline stage,
// and the block accepts requests in the first cycle after reset is released.
module quadratic_root_solver import qrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [DATA_W-1:0] coef_a_i,
  input  logic [DATA_W-1:0] coef_b_i,
  input  logic [DATA_W-1:0] coef_c_i,
  output logic              empty,
  input  logic              pop,
  output logic [DATA_W-1:0] root_plus_o,
  output logic [DATA_W-1:0] root_minus_o,
  output logic [1:0]        status_o
);

  logic mid_full, mid_push, mid_empty, mid_pop;
  mid_t mid_wdata, mid_rdata;

  qrs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .coef_a_i   (coef_a_i),
    .coef_b_i   (coef_b_i),
    .coef_c_i   (coef_c_i),
    .mid_full_i (mid_full),
    .mid_push_o (mid_push),
    .mid_data_o (mid_wdata)
  );

  qrs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .empty_o (mid_empty),
    .data_o  (mid_rdata)
  );

  qrs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mid_empty_i  (mid_empty),
    .mid_data_i   (mid_rdata),
    .mid_pop_o    (mid_pop),
    .empty        (empty),
    .pop          (pop),
    .root_plus_o  (root_plus_o),
    .root_minus_o (root_minus_o),
    .status_o     (status_o)
  );

endmodule

FILE: rtl/qrs_front.sv
module qrs_front import qrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [DATA_W-1:0] coef_a_i,
  input  logic [DATA_W-1:0] coef_b_i,
  input  logic [DATA_W-1:0] coef_c_i,
  input  logic              mid_full_i,
  output logic              mid_push_o,
  output mid_t              mid_data_o
);

  logic                f1_v_q, f2_v_q, adv;
  logic                f1_an_q, f1_bn_q, f1_cn_q;
  logic [DATA_W-1:0]   f1_ma_q, f1_mb_q, f1_mc_q;
  logic                f2_an_q, f2_bn_q, f2_same_q;
  logic [DATA_W-1:0]   f2_ma_q, f2_mb_q;
  logic [2*DATA_W-1:0] f2_bsq_q, f2_mac_q;
  logic [DISC_W:0]     disc;

  // The front only holds when its last stage has a request the queue cannot take.
  assign adv    = !(f2_v_q && mid_full_i);
  assign full_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else if (adv) begin
      f1_v_q <= push_i;
      f2_v_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_an_q   <= coef_a_i[DATA_W-1];
      f1_bn_q   <= coef_b_i[DATA_W-1];
      f1_cn_q   <= coef_c_i[DATA_W-1];
      f1_ma_q   <= coef_a_i[DATA_W-1] ? -coef_a_i : coef_a_i;
      f1_mb_q   <= coef_b_i[DATA_W-1] ? -coef_b_i : coef_b_i;
      f1_mc_q   <= coef_c_i[DATA_W-1] ? -coef_c_i : coef_c_i;
      f2_an_q   <= f1_an_q;
      f2_bn_q   <= f1_bn_q;
      f2_same_q <= (f1_an_q == f1_cn_q);
      f2_ma_q   <= f1_ma_q;
      f2_mb_q   <= f1_mb_q;
      f2_bsq_q  <= f1_mb_q * f1_mb_q;
      f2_mac_q  <= f1_ma_q * f1_mc_q;
    end
  end

  always_comb begin
    if (f2_same_q) begin
      disc = {3'b000, f2_bsq_q} - {1'b0, f2_mac_q, 2'b00};
    end else begin
      disc = {3'b000, f2_bsq_q} + {1'b0, f2_mac_q, 2'b00};
    end
    mid_data_o.an   = f2_an_q;
    mid_data_o.bn   = f2_bn_q;
    mid_data_o.ma   = f2_ma_q;
    mid_data_o.mb   = f2_mb_q;
    mid_data_o.disc = disc[DISC_W-1:0];
    if (f2_ma_q == '0) begin
      mid_data_o.st = ST_ZERO_A;
    end else if (disc[DISC_W]) begin
      mid_data_o.st = ST_NEG_DISC;
    end else begin
      mid_data_o.st = ST_OK;
    end
  end

  assign mid_push_o = adv && f2_v_q;

endmodule

FILE: rtl/qrs_queue.sv
module qrs_queue import qrs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  mid_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output mid_t data_o
);

  localparam int PTR_W = $clog2(MIDQ_DEPTH);

  mid_t             mem_q [MIDQ_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PTR_W+1)'(MIDQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(MIDQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(MIDQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/qrs_back.sv
module qrs_back import qrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              mid_empty_i,
  input  mid_t              mid_data_i,
  output logic              mid_pop_o,
  output logic              empty,
  input  logic              pop,
  output logic [DATA_W-1:0] root_plus_o,
  output logic [DATA_W-1:0] root_minus_o,
  output logic [1:0]        status_o
);

  typedef struct packed {
    status_e           st;
    logic              an;
    logic              bn;
    logic [DATA_W-1:0] ma;
    logic [DATA_W-1:0] mb;
  } sq_side_t;

  typedef struct packed {
    status_e           st;
    logic              an;
    logic              s1;
    logic              s2;
    logic [DATA_W-1:0] ma;
  } dv_side_t;

  typedef struct packed {
    logic [DATA_W-1:0] rp;
    logic [DATA_W-1:0] rm;
    status_e           st;
  } res_t;

  localparam int OPTR_W = $clog2(OUTQ_DEPTH);

  logic                adv;
  logic [SQ_STEPS:0]   sq_v_q, sq_v_d;
  logic [REM_W-1:0]    sq_rem_q  [SQ_STEPS+1];
  logic [REM_W-1:0]    sq_rem_d  [SQ_STEPS+1];
  logic [ROOT_W-1:0]   sq_root_q [SQ_STEPS+1];
  logic [ROOT_W-1:0]   sq_root_d [SQ_STEPS+1];
  logic [DISC_W-1:0]   sq_rad_q  [SQ_STEPS+1];
  logic [DISC_W-1:0]   sq_rad_d  [SQ_STEPS+1];
  sq_side_t            sq_sd_q   [SQ_STEPS+1];
  sq_side_t            sq_sd_d   [SQ_STEPS+1];

  logic [DIV_STEPS:0]  dv_v_q, dv_v_d;
  logic [DEN_W-1:0]    dv_r1_q [DIV_STEPS+1];
  logic [DEN_W-1:0]    dv_r1_d [DIV_STEPS+1];
  logic [DEN_W-1:0]    dv_r2_q [DIV_STEPS+1];
  logic [DEN_W-1:0]    dv_r2_d [DIV_STEPS+1];
  logic [QUO_W-1:0]    dv_q1_q [DIV_STEPS+1];
  logic [QUO_W-1:0]    dv_q1_d [DIV_STEPS+1];
  logic [QUO_W-1:0]    dv_q2_q [DIV_STEPS+1];
  logic [QUO_W-1:0]    dv_q2_d [DIV_STEPS+1];
  logic [QUO_W-1:0]    dv_n1_q [DIV_STEPS+1];
  logic [QUO_W-1:0]    dv_n1_d [DIV_STEPS+1];
  logic [QUO_W-1:0]    dv_n2_q [DIV_STEPS+1];
  logic [QUO_W-1:0]    dv_n2_d [DIV_STEPS+1];
  dv_side_t            dv_sd_q [DIV_STEPS+1];
  dv_side_t            dv_sd_d [DIV_STEPS+1];

  logic [REM_W+1:0]    sq_sh   [SQ_STEPS];
  logic [REM_W+1:0]    sq_tr   [SQ_STEPS];
  logic [DEN_W:0]      dv_sh1  [DIV_STEPS];
  logic [DEN_W:0]      dv_sh2  [DIV_STEPS];
  logic [DEN_W:0]      dv_den  [DIV_STEPS];
  logic [NUM_W-1:0]    nb, nsq, n1, n2, m1, m2;

  res_t                oq_q [OUTQ_DEPTH];
  res_t                res;
  logic [OPTR_W-1:0]   owr_q, ord_q;
  logic [OPTR_W:0]     ocnt_q;
  logic                ofull, opush, opop, sat1, sat2;
  logic [DATA_W-1:0]   v1, v2;

  // Saturate a truncated quotient to the signed output range and apply its sign.
  function automatic logic [DATA_W:0] finish_root(input logic [QUO_W-1:0] q,
                                                  input logic neg_in);
    logic             neg;
    logic [QUO_W-1:0] lim;
    logic             sat;
    logic [DATA_W-1:0] mag;
    neg = neg_in && (q != '0);
    lim = neg ? (QUO_W'(1) << (DATA_W - 1)) : ((QUO_W'(1) << (DATA_W - 1)) - 1'b1);
    sat = (q > lim);
    mag = sat ? lim[DATA_W-1:0] : q[DATA_W-1:0];
    return {sat, neg ? -mag : mag};
  endfunction

  assign ofull     = (ocnt_q == (OPTR_W+1)'(OUTQ_DEPTH));
  assign adv       = !ofull;
  assign mid_pop_o = adv && !mid_empty_i;

  always_comb begin
    sq_v_d[0]    = !mid_empty_i;
    sq_rem_d[0]  = '0;
    sq_root_d[0] = '0;
    sq_rad_d[0]  = mid_data_i.disc;
    sq_sd_d[0]   = '{st: mid_data_i.st, an: mid_data_i.an, bn: mid_data_i.bn,
                     ma: mid_data_i.ma, mb: mid_data_i.mb};
    // One result bit of the square root per stage.
    for (int k = 0; k < SQ_STEPS; k++) begin
      sq_sh[k] = {sq_rem_q[k], sq_rad_q[k][DISC_W-1 -: 2]};
      sq_tr[k] = {2'b00, sq_root_q[k], 2'b01};
      sq_v_d[k+1]   = sq_v_q[k];
      sq_sd_d[k+1]  = sq_sd_q[k];
      sq_rad_d[k+1] = {sq_rad_q[k][DISC_W-3:0], 2'b00};
      if (sq_sh[k] >= sq_tr[k]) begin
        sq_rem_d[k+1]  = REM_W'(sq_sh[k] - sq_tr[k]);
        sq_root_d[k+1] = {sq_root_q[k][ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem_d[k+1]  = sq_sh[k][REM_W-1:0];
        sq_root_d[k+1] = {sq_root_q[k][ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Numerators -b + sqrt(d) and -b - sqrt(d) in two's complement.
  always_comb begin
    nb  = sq_sd_q[SQ_STEPS].bn ? NUM_W'(sq_sd_q[SQ_STEPS].mb)
                               : -NUM_W'(sq_sd_q[SQ_STEPS].mb);
    nsq = NUM_W'(sq_root_q[SQ_STEPS]);
    n1  = nb + nsq;
    n2  = nb - nsq;
    m1  = n1[NUM_W-1] ? -n1 : n1;
    m2  = n2[NUM_W-1] ? -n2 : n2;
  end

  always_comb begin
    dv_v_d[0]  = sq_v_q[SQ_STEPS];
    dv_r1_d[0] = '0;
    dv_r2_d[0] = '0;
    dv_q1_d[0] = '0;
    dv_q2_d[0] = '0;
    dv_n1_d[0] = {m1[NMAG_W-1:0], {FRAC_W{1'b0}}};
    dv_n2_d[0] = {m2[NMAG_W-1:0], {FRAC_W{1'b0}}};
    dv_sd_d[0] = '{st: sq_sd_q[SQ_STEPS].st, an: sq_sd_q[SQ_STEPS].an,
                   s1: n1[NUM_W-1], s2: n2[NUM_W-1], ma: sq_sd_q[SQ_STEPS].ma};
    // Restoring division of both numerators by 2a, one quotient bit per stage.
    for (int j = 0; j < DIV_STEPS; j++) begin
      dv_den[j] = {1'b0, dv_sd_q[j].ma, 1'b0};
      dv_sh1[j] = {dv_r1_q[j], dv_n1_q[j][QUO_W-1]};
      dv_sh2[j] = {dv_r2_q[j], dv_n2_q[j][QUO_W-1]};
      dv_v_d[j+1]  = dv_v_q[j];
      dv_sd_d[j+1] = dv_sd_q[j];
      dv_n1_d[j+1] = {dv_n1_q[j][QUO_W-2:0], 1'b0};
      dv_n2_d[j+1] = {dv_n2_q[j][QUO_W-2:0], 1'b0};
      if (dv_sh1[j] >= dv_den[j]) begin
        dv_r1_d[j+1] = DEN_W'(dv_sh1[j] - dv_den[j]);
        dv_q1_d[j+1] = {dv_q1_q[j][QUO_W-2:0], 1'b1};
      end else begin
        dv_r1_d[j+1] = dv_sh1[j][DEN_W-1:0];
        dv_q1_d[j+1] = {dv_q1_q[j][QUO_W-2:0], 1'b0};
      end
      if (dv_sh2[j] >= dv_den[j]) begin
        dv_r2_d[j+1] = DEN_W'(dv_sh2[j] - dv_den[j]);
        dv_q2_d[j+1] = {dv_q2_q[j][QUO_W-2:0], 1'b1};
      end else begin
        dv_r2_d[j+1] = dv_sh2[j][DEN_W-1:0];
        dv_q2_d[j+1] = {dv_q2_q[j][QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q <= '0;
      dv_v_q <= '0;
    end else if (adv) begin
      sq_v_q <= sq_v_d;
      dv_v_q <= dv_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_rem_q  <= sq_rem_d;
      sq_root_q <= sq_root_d;
      sq_rad_q  <= sq_rad_d;
      sq_sd_q   <= sq_sd_d;
      dv_r1_q   <= dv_r1_d;
      dv_r2_q   <= dv_r2_d;
      dv_q1_q   <= dv_q1_d;
      dv_q2_q   <= dv_q2_d;
      dv_n1_q   <= dv_n1_d;
      dv_n2_q   <= dv_n2_d;
      dv_sd_q   <= dv_sd_d;
    end
  end

  always_comb begin
    {sat1, v1} = finish_root(dv_q1_q[DIV_STEPS],
                             dv_sd_q[DIV_STEPS].s1 != dv_sd_q[DIV_STEPS].an);
    {sat2, v2} = finish_root(dv_q2_q[DIV_STEPS],
                             dv_sd_q[DIV_STEPS].s2 != dv_sd_q[DIV_STEPS].an);
    if (dv_sd_q[DIV_STEPS].st != ST_OK) begin
      res = '{rp: '0, rm: '0, st: dv_sd_q[DIV_STEPS].st};
    end else begin
      res = '{rp: v1, rm: v2, st: (sat1 || sat2) ? ST_SAT : ST_OK};
    end
  end

  assign opush        = adv && dv_v_q[DIV_STEPS];
  assign opop         = pop && !empty;
  assign empty        = (ocnt_q == '0);
  assign root_plus_o  = oq_q[ord_q].rp;
  assign root_minus_o = oq_q[ord_q].rm;
  assign status_o     = oq_q[ord_q].st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= '0;
      ord_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (opush) begin
        owr_q <= (owr_q == OPTR_W'(OUTQ_DEPTH - 1)) ? '0 : owr_q + 1'b1;
      end
      if (opop) begin
        ord_q <= (ord_q == OPTR_W'(OUTQ_DEPTH - 1)) ? '0 : ord_q + 1'b1;
      end
      ocnt_q <= ocnt_q + (OPTR_W+1)'(opush) - (OPTR_W+1)'(opop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) begin
      oq_q[owr_q] <= res;
    end
  end

endmodule

FILE: rtl/qrs_checker.sv
module qrs_checker import qrs_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input logic [DATA_W-1:0] root_plus_o,
  input logic [DATA_W-1:0] root_minus_o,
  input logic [1:0]        status_o
);

  localparam logic [DATA_W-1:0] MAX_V = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MIN_V = {1'b1, {(DATA_W-1){1'b0}}};

  // Nothing is offered while reset is held.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result offered during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(root_plus_o) && $stable(root_minus_o)
                          && $stable(status_o)))
    else $error("waiting result changed");

  a_no_roots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o == ST_NEG_DISC || status_o == ST_ZERO_A))
      |-> (root_plus_o == '0 && root_minus_o == '0))
    else $error("roots given with no real solution");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == ST_SAT)
      |-> (root_plus_o == MAX_V || root_plus_o == MIN_V ||
           root_minus_o == MAX_V || root_minus_o == MIN_V))
    else $error("saturation reported without a clamped root");

endmodule

bind quadratic_root_solver qrs_checker u_chk (.*);
